[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker file.
// Each macro takes a label, the clock, the active-low reset, the terms
// of the property and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define RWP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define RWP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rwp_pkg.sv]
// ----------------------------------------------------------------------------
// rwp_pkg
// Shared types, register indexes and constants of the weight perturbation
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package rwp_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE   = 3'd5;

    // field widths
    localparam int SHIFT_W = 5;
    localparam int CW_W    = 16;
    localparam int OFS_W   = 24;
    localparam int WORD_W  = 32;
    localparam int BIT_CNT_W = 5;   // bit position within one 32-bit noise word

    // seed whitening
    localparam logic [WORD_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [WORD_W-1:0] LCG_INC = 32'd1013904223;

    // narrow mode clamp
    localparam int SAT_HI = 127;
    localparam int SAT_LO = -127;

    // offset divider: one quotient bit per cycle
    localparam int DIV_STEPS = OFS_W;

    // controller -> datapath
    typedef struct packed {
        logic load_wr;   // write multiplier table entry
        logic take;      // capture weight item
        logic restart;   // first weight: reseed, clear bit count, start divider
        logic step;      // draw sign bit, read table, advance channel
        logic noise;     // form scaled noise
        logic emit;      // load result register
    } t_rwp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_rwp_stat;

    function automatic logic [WORD_W-1:0] xs32(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage

`default_nettype wire

[rtl/rwp_in_if.sv]
// ----------------------------------------------------------------------------
// rwp_in_if
// Input item channel: load items and weight items.
// ----------------------------------------------------------------------------
`default_nettype none

interface rwp_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [7:0]         table_index;
    logic signed [31:0] multiplier;
    logic signed [31:0] weight;
    logic               first;
    logic               last;

    modport source (
        output valid, kind, table_index, multiplier, weight, first, last,
        input  ready
    );
    modport sink (
        input  valid, kind, table_index, multiplier, weight, first, last,
        output ready
    );
endinterface

`default_nettype wire

[rtl/rwp_out_if.sv]
// ----------------------------------------------------------------------------
// rwp_out_if
// Result channel: perturbed weight and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface rwp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] perturbed;
    logic               index_error;
    logic               last_out;

    modport source (
        output valid, perturbed, index_error, last_out,
        input  ready
    );
    modport sink (
        input  valid, perturbed, index_error, last_out,
        output ready
    );
endinterface

`default_nettype wire

[rtl/rwp_divider.sv]
// ----------------------------------------------------------------------------
// rwp_divider
// Restoring divider, start offset by channel width, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rwp_divider (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rwp_pkg::OFS_W-1:0]   i_dividend,
    input  wire logic [rwp_pkg::CW_W-1:0]    i_divisor,
    output logic                             o_done,
    output logic [rwp_pkg::OFS_W-1:0]        o_quot,
    output logic [rwp_pkg::CW_W-1:0]         o_rem
);

    localparam int QW = rwp_pkg::OFS_W;
    localparam int RW = rwp_pkg::CW_W;
    localparam int CNT_W = $clog2(rwp_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(rwp_pkg::DIV_STEPS - 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [QW-1:0]   r_quot, n_quot;
    logic [RW-1:0]   r_rem, n_rem;
    logic [RW-1:0]   r_div, n_div;

    logic [RW:0]     w_trial;
    logic [RW:0]     w_diff;
    logic            w_fits;

    assign w_trial = {r_rem, r_quot[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fits  = w_trial >= {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quot = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quot = {r_quot[QW-2:0], w_fits};
            n_rem  = w_fits ? w_diff[RW-1:0] : w_trial[RW-1:0];
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[rtl/rwp_datapath.sv]
// ----------------------------------------------------------------------------
// rwp_datapath
// Configuration registers, offset divider, multiplier table, noise generator,
// channel counters, noise scaling, final add and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rwp_datapath #(
    parameter int MAX_CHANNELS = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rwp_pkg::t_rwp_cmd                 i_cmd,
    output rwp_pkg::t_rwp_stat                     o_stat,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [rwp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rwp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input payload
    input  wire logic [7:0]                        i_table_index,
    input  wire logic signed [31:0]                i_multiplier,
    input  wire logic signed [31:0]                i_weight,
    input  wire logic                              i_last,
    // result
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [31:0]                     o_perturbed,
    output logic                                   o_index_error,
    output logic                                   o_last_out
);

    localparam int AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WW     = rwp_pkg::WORD_W;
    localparam int CWW    = rwp_pkg::CW_W;
    localparam int OW     = rwp_pkg::OFS_W;
    localparam int NW     = WW + 2;       // noise: +-m plus rounding half
    localparam int SW     = NW + 1;       // narrow sum
    localparam int LIDX_W = 13;           // holds MAX_CHANNELS up to 4096
    localparam logic [LIDX_W-1:0] MAX_L = LIDX_W'(MAX_CHANNELS);
    localparam logic [OW:0]       MAX_C = (OW + 1)'(MAX_CHANNELS);
    localparam logic signed [SW-1:0] L_HI = SW'(rwp_pkg::SAT_HI);
    localparam logic signed [SW-1:0] L_LO = SW'(rwp_pkg::SAT_LO);

    // configuration registers
    logic [rwp_pkg::SHIFT_W-1:0] r_shift;
    logic [CWW-1:0]              r_cw;
    logic [WW-1:0]               r_seed;
    logic [OW-1:0]               r_start;
    logic                        r_idx_mode;
    logic                        r_wide_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_cw        <= CWW'(1);
            r_seed      <= '0;
            r_start     <= '0;
            r_idx_mode  <= 1'b0;
            r_wide_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rwp_pkg::CFG_SHIFT:      r_shift     <= i_cfg_data[rwp_pkg::SHIFT_W-1:0];
                rwp_pkg::CFG_CHAN_WIDTH: r_cw        <= i_cfg_data[CWW-1:0];
                rwp_pkg::CFG_SEED:       r_seed      <= i_cfg_data[WW-1:0];
                rwp_pkg::CFG_START_OFS:  r_start     <= i_cfg_data[OW-1:0];
                rwp_pkg::CFG_INDEX_MODE: r_idx_mode  <= i_cfg_data[0];
                rwp_pkg::CFG_WIDE_MODE:  r_wide_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // zero width behaves as one
    logic [CWW-1:0] w_cw;
    assign w_cw = (r_cw == '0) ? CWW'(1) : r_cw;

    // offset divider
    logic           w_div_done;
    logic [OW-1:0]  w_div_quot;
    logic [CWW-1:0] w_div_rem;

    rwp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.restart),
        .i_dividend (r_start),
        .i_divisor  (w_cw),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    // multiplier table
    logic [WW-1:0] r_mem [0:MAX_CHANNELS-1];
    logic [31:0]   w_tidx_ext;
    logic          w_load_ok;
    assign w_tidx_ext = 32'(i_table_index);
    assign w_load_ok  = {5'b0, i_table_index} < MAX_L;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && w_load_ok) begin
            r_mem[w_tidx_ext[AW-1:0]] <= i_multiplier;
        end
    end

    // generator and channel state
    logic [WW-1:0]                 r_gen;
    logic [WW-1:0]                 r_bw;
    logic [rwp_pkg::BIT_CNT_W-1:0] r_bc;
    logic [CWW-1:0]                r_rem;
    logic [OW-1:0]                 r_quot;

    logic [WW-1:0]  w_xs;
    logic [WW-1:0]  w_word;
    logic [OW-1:0]  w_chan;
    logic           w_err;
    logic [CWW:0]   w_rem_inc;
    logic [WW-1:0]  w_lcg;

    assign w_xs      = rwp_pkg::xs32(r_gen);
    assign w_word    = (r_bc == '0) ? w_xs : r_bw;
    assign w_chan    = r_idx_mode ? r_quot : OW'(r_rem);
    assign w_err     = {1'b0, w_chan} >= MAX_C;
    assign w_rem_inc = {1'b0, r_rem} + 1'b1;
    assign w_lcg     = r_seed * rwp_pkg::LCG_MUL + rwp_pkg::LCG_INC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen  <= '0;
            r_bw   <= '0;
            r_bc   <= '0;
            r_rem  <= '0;
            r_quot <= '0;
        end else begin
            if (i_cmd.restart) begin
                r_gen <= w_lcg;
                r_bc  <= '0;
            end
            if (w_div_done) begin
                r_rem  <= w_div_rem;
                r_quot <= w_div_quot;
            end
            if (i_cmd.step) begin
                if (r_bc == '0) begin
                    r_gen <= w_xs;
                    r_bw  <= w_xs;
                end
                r_bc <= r_bc + 1'b1;
                if (w_rem_inc >= {1'b0, w_cw}) begin
                    r_rem  <= '0;
                    r_quot <= r_quot + 1'b1;
                end else begin
                    r_rem <= w_rem_inc[CWW-1:0];
                end
            end
        end
    end

    // item registers
    logic signed [WW-1:0] r_w;
    logic                 r_last;
    logic                 r_sbit;
    logic                 r_err;
    logic [WW-1:0]        r_m;
    logic signed [NW-1:0] r_noise;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_w    <= i_weight;
            r_last <= i_last;
        end
        if (i_cmd.step) begin
            r_sbit <= w_word[r_bc];
            r_err  <= w_err;
            r_m    <= r_mem[w_chan[AW-1:0]];
        end
    end

    // noise = (+-m + round) >>> shift
    logic signed [NW-1:0] w_m_ext;
    logic signed [NW-1:0] w_round;
    logic signed [NW-1:0] w_prod;
    logic signed [NW-1:0] w_noise;

    assign w_m_ext = NW'($signed(r_m));
    assign w_round = $signed((NW'(1) << r_shift) >> 1);
    assign w_prod  = (r_sbit ? w_m_ext : -w_m_ext) + w_round;
    assign w_noise = w_prod >>> r_shift;

    always_ff @(posedge i_clk) begin
        if (i_cmd.noise) begin
            r_noise <= r_err ? '0 : w_noise;
        end
    end

    // final add: wrap in wide mode, clamp in narrow mode
    logic [WW-1:0]        w_sum_wide;
    logic signed [SW-1:0] w_sum_nar;
    logic signed [SW-1:0] w_clamp;
    logic [WW-1:0]        w_result;

    assign w_sum_wide = r_w + r_noise[WW-1:0];
    assign w_sum_nar  = SW'($signed(r_w[7:0])) + SW'(r_noise);

    always_comb begin
        if (w_sum_nar > L_HI) begin
            w_clamp = L_HI;
        end else if (w_sum_nar < L_LO) begin
            w_clamp = L_LO;
        end else begin
            w_clamp = w_sum_nar;
        end
    end

    assign w_result = r_wide_mode ? w_sum_wide : w_clamp[WW-1:0];

    // result register
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_perturbed   <= $signed(w_result);
            o_index_error <= r_err;
            o_last_out    <= r_last;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = !r_ov || i_out_ready;

endmodule

`default_nettype wire

[rtl/rwp_ctrl.sv]
// ----------------------------------------------------------------------------
// rwp_ctrl
// Sequencer: accepts items, waits for the offset divider on a first weight,
// then steps the datapath through draw, scale and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module rwp_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_kind,
    input  wire logic                i_in_first,
    output logic                     o_in_ready,
    input  wire rwp_pkg::t_rwp_stat  i_stat,
    output rwp_pkg::t_rwp_cmd        o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_STEP  = 3'd2;
    localparam logic [2:0] ST_NOISE = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;

    localparam logic KIND_LOAD = 1'b0;

    logic [2:0] r_state, n_state;
    logic       w_xfer;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_xfer     = i_in_valid && o_in_ready;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.load_wr = w_xfer && (i_in_kind == KIND_LOAD);
        o_cmd.take    = w_xfer && (i_in_kind != KIND_LOAD);
        o_cmd.restart = o_cmd.take && i_in_first;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.take) begin
                    n_state = i_in_first ? ST_DIV : ST_STEP;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = ST_NOISE;
            end
            ST_NOISE: begin
                o_cmd.noise = 1'b1;
                n_state     = ST_SUM;
            end
            ST_SUM: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/rademacher_weight_perturb_top.sv]
// ----------------------------------------------------------------------------
// rademacher_weight_perturb_top
// Adds per-channel scaled Rademacher noise to a stream of quantized weights.
//
//  channel   dir  transfer                 payload
//  i_in      in   valid & ready            kind, table_index, multiplier,
//                                          weight, first, last
//  o_out     out  valid & ready            perturbed, index_error, last_out
//  i_cfg_*   in   i_cfg_we                 i_cfg_idx, i_cfg_data
//
// A load item is handled in the accept step alone. A weight item passes
// accept, draw and table read, scale and add; the table's registered read port
// sets the split. A first weight also waits for the bit-serial offset divider.
// Reset is synchronous, active low; the multiplier table is not cleared.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits in the add step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module rademacher_weight_perturb_top #(
    parameter int MAX_CHANNELS = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    rwp_in_if.sink                               i_in,
    rwp_out_if.source                            o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [rwp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [rwp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    rwp_pkg::t_rwp_cmd  w_cmd;
    rwp_pkg::t_rwp_stat w_stat;
    logic               w_in_ready;

    rwp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_in_first (i_in.first),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rwp_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_table_index (i_in.table_index),
        .i_multiplier  (i_in.multiplier),
        .i_weight      (i_in.weight),
        .i_last        (i_in.last),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_perturbed   (o_out.perturbed),
        .o_index_error (o_out.index_error),
        .o_last_out    (o_out.last_out)
    );

    assign i_in.ready = w_in_ready;

endmodule

`default_nettype wire

[rtl/rwp_checker.sv]
// ----------------------------------------------------------------------------
// rwp_checker
// Port-level checks of the weight perturbation block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rwp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_in_kind,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [33:0] i_out_bits
);

    logic w_in_xfer;
    logic w_out_stall;
    assign w_in_xfer   = i_in_valid && i_in_ready;
    assign w_out_stall = i_out_valid && !i_out_ready;

    // a result stays offered until its transfer
    `RWP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, i_out_valid, "result dropped while stalled")

    // a stalled result keeps its bits
    `RWP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_out_stall, $stable(i_out_bits), "result changed while stalled")

    // a load item never produces a result
    `RWP_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, w_in_xfer && !i_in_kind && !i_out_valid, !i_out_valid, "load item produced a result")

    // a weight item is worked on alone
    `RWP_ASSERT_NEXT(a_weight_busy, i_clk, i_rst_n, w_in_xfer && i_in_kind, !i_in_ready, "input taken while a weight is in work")

endmodule

bind rademacher_weight_perturb_top rwp_checker u_rwp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_kind   (i_in.kind),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_bits  ({o_out.perturbed, o_out.index_error, o_out.last_out})
);

`default_nettype wire

[tb/rwp_perturb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwp_perturb_checker
// Watches the item, result and register ports of the weight perturbation
// block, keeps its own copy of table, generator and channel state, works out
// the perturbed weight for every accepted weight item and compares each
// result transfer against the oldest pending prediction.
// ----------------------------------------------------------------------------

module rwp_perturb_checker #(
    parameter int   MAX_CHANNELS = 256,
    parameter logic WEIGHT_KIND  = 1'b1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    rwp_in_if                                    item_ch,
    rwp_out_if                                   result_ch,
    input  wire logic                            i_cfg_we,
    input  wire logic [rwp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [rwp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    localparam int TBL_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    typedef struct packed {
        logic [31:0] perturbed;
        logic        index_error;
        logic        last_out;
    } t_perturb_result;

    t_perturb_result expected_results_q[$];
    t_perturb_result want;
    t_perturb_result got;

    // predictor state
    logic [31:0] mult_tbl [MAX_CHANNELS];
    logic [31:0] gen_state;
    logic [31:0] noise_word;
    logic [4:0]  bit_pos;
    logic [15:0] chan_rem;
    logic [23:0] chan_quo;

    // register copy
    logic [4:0]  cfg_shift;
    logic [15:0] cfg_cw;
    logic [31:0] cfg_seed;
    logic [23:0] cfg_ofs;
    logic        cfg_idx_mode;
    logic        cfg_wide;

    int fail_count    = 0;
    int pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic logic [31:0] xorshift_step(input logic [31:0] x);
        logic [31:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        return t ^ (t << 5);
    endfunction

    task automatic predict_perturbed(input logic [31:0] weight, input logic first,
                                     input logic last, output t_perturb_result res);
        logic [15:0]        cw;
        logic [16:0]        rem_next;
        logic               sbit;
        logic [23:0]        chan;
        logic               err;
        logic signed [63:0] m;
        logic signed [63:0] prod;
        logic signed [63:0] noise;
        logic signed [63:0] w;
        logic signed [63:0] sum;

        cw = (cfg_cw == 16'd0) ? 16'd1 : cfg_cw;
        if (first) begin
            gen_state = cfg_seed * rwp_pkg::LCG_MUL + rwp_pkg::LCG_INC;
            bit_pos   = 5'd0;
            chan_rem  = 16'(cfg_ofs % cw);
            chan_quo  = 24'(cfg_ofs / cw);
        end
        if (bit_pos == 5'd0) begin
            gen_state  = xorshift_step(gen_state);
            noise_word = gen_state;
        end
        sbit    = noise_word[bit_pos];
        bit_pos = bit_pos + 5'd1;

        chan = cfg_idx_mode ? chan_quo : {8'd0, chan_rem};
        err  = (chan >= MAX_CHANNELS);
        if (err) begin
            noise = 64'sd0;
        end else begin
            m    = $signed(mult_tbl[chan[TBL_AW-1:0]]);
            prod = sbit ? m : -m;
            if (cfg_shift != 5'd0) prod = prod + (64'sd1 << (cfg_shift - 5'd1));
            noise = prod >>> cfg_shift;
        end

        rem_next = {1'b0, chan_rem} + 17'd1;
        if (rem_next >= {1'b0, cw}) begin
            chan_rem = 16'd0;
            chan_quo = chan_quo + 24'd1;
        end else begin
            chan_rem = rem_next[15:0];
        end

        if (cfg_wide) begin
            w   = $signed(weight);
            sum = w + noise;
        end else begin
            w   = $signed(weight[7:0]);
            sum = w + noise;
            if (sum > rwp_pkg::SAT_HI) sum = rwp_pkg::SAT_HI;
            if (sum < rwp_pkg::SAT_LO) sum = rwp_pkg::SAT_LO;
        end
        res.perturbed   = sum[31:0];
        res.index_error = err;
        res.last_out    = last;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gen_state    = '0;
            noise_word   = '0;
            bit_pos      = '0;
            chan_rem     = '0;
            chan_quo     = '0;
            cfg_shift    = '0;
            cfg_cw       = 16'd1;
            cfg_seed     = '0;
            cfg_ofs      = '0;
            cfg_idx_mode = 1'b0;
            cfg_wide     = 1'b0;
            expected_results_q.delete();
        end else begin
            // results leave before the same-edge item enters
            if (result_ch.valid && result_ch.ready) begin
                if (expected_results_q.size() == 0) begin
                    $error("perturbed: unexpected result transfer, actual %0d",
                           $signed(result_ch.perturbed));
                    fail_count++;
                end else begin
                    want = expected_results_q.pop_front();
                    got  = '{result_ch.perturbed, result_ch.index_error, result_ch.last_out};
                    if (got.perturbed !== want.perturbed) begin
                        $error("perturbed: expected %0d, actual %0d",
                               $signed(want.perturbed), $signed(got.perturbed));
                        fail_count++;
                    end
                    if (got.index_error !== want.index_error) begin
                        $error("index_error: expected %0b, actual %0b",
                               want.index_error, got.index_error);
                        fail_count++;
                    end
                    if (got.last_out !== want.last_out) begin
                        $error("last_out: expected %0b, actual %0b",
                               want.last_out, got.last_out);
                        fail_count++;
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rwp_pkg::CFG_SHIFT:      cfg_shift    = i_cfg_data[4:0];
                    rwp_pkg::CFG_CHAN_WIDTH: cfg_cw       = i_cfg_data[15:0];
                    rwp_pkg::CFG_SEED:       cfg_seed     = i_cfg_data;
                    rwp_pkg::CFG_START_OFS:  cfg_ofs      = i_cfg_data[23:0];
                    rwp_pkg::CFG_INDEX_MODE: cfg_idx_mode = i_cfg_data[0];
                    rwp_pkg::CFG_WIDE_MODE:  cfg_wide     = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (item_ch.valid && item_ch.ready) begin
                if (item_ch.kind == WEIGHT_KIND) begin
                    predict_perturbed(item_ch.weight, item_ch.first, item_ch.last, want);
                    expected_results_q.push_back(want);
                end else if (item_ch.table_index < MAX_CHANNELS) begin
                    mult_tbl[item_ch.table_index] = item_ch.multiplier;
                end
            end
        end
        pending_count = expected_results_q.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the weight perturbation block: fills the
// multiplier table, runs directed corner cases and then randomized tensor
// streams over a series of register settings, with random idling on both
// channels. Checking is done by the checker instance.
// ----------------------------------------------------------------------------

module tb;

    localparam int   MAX_CHANNELS = 256;
    localparam logic ITEM_LOAD    = 1'b0;
    localparam logic ITEM_WEIGHT  = 1'b1;
    localparam int   MAX_GAP      = 11;
    localparam int   DRAIN_CYCLES = 40;   // weight pipe plus offset divider
    localparam int   PHASES       = 12;
    localparam int   PHASE_ITEMS  = 60;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [rwp_pkg::CFG_IDX_W-1:0]   cfg_idx;
    logic [rwp_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                              fail_count;
    int                              pending;
    bit                              item_calm;
    bit                              result_calm;
    bit                              wide_now;

    rwp_in_if  item_if ();
    rwp_out_if result_if ();

    always #4 clk = ~clk;

    rademacher_weight_perturb_top #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (item_if),
        .o_out      (result_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rwp_perturb_checker #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .WEIGHT_KIND  (ITEM_WEIGHT)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .item_ch      (item_if),
        .result_ch    (result_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [31:0] rand_mult();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0001;
            default: v = 32'($signed($urandom) >>> $urandom_range(0, 31));
        endcase
        if (v == 32'h8000_0000) v = 32'h8000_0001;
        return v;
    endfunction

    function automatic logic [31:0] rand_weight(input bit wide);
        logic [7:0] b;
        b = 8'($urandom);
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            4:       return wide ? 32'h0000_0000 : 32'h0000_007F;
            5:       return wide ? 32'hFFFF_FFFF : 32'hFFFF_FF80;
            default: return wide ? $urandom : {{24{b[7]}}, b};
        endcase
    endfunction

    // one item transfer; valid stays high across back-to-back items
    task automatic send_item(input logic kind, input logic [7:0] tidx,
                             input logic [31:0] mult, input logic [31:0] weight,
                             input logic first, input logic last);
        int gap;
        if ($urandom_range(0, 39) == 0) item_calm = !item_calm;
        gap = item_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_if.valid       <= 1'b1;
        item_if.kind        <= kind;
        item_if.table_index <= tidx;
        item_if.multiplier  <= mult;
        item_if.weight      <= weight;
        item_if.first       <= first;
        item_if.last        <= last;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_weight(input logic [31:0] weight, input logic first,
                               input logic last);
        send_item(ITEM_WEIGHT, 8'($urandom), $urandom, weight, first, last);
    endtask

    task automatic send_load(input logic [7:0] tidx, input logic [31:0] mult);
        send_item(ITEM_LOAD, tidx, mult, $urandom, 1'($urandom), 1'($urandom));
    endtask

    task automatic program_regs(input logic [4:0] shift, input logic [15:0] cw,
                                input logic [31:0] seed, input logic [23:0] ofs,
                                input logic idx_mode, input logic wide);
        logic [rwp_pkg::CFG_IDX_W-1:0]  reg_idx [6];
        logic [rwp_pkg::CFG_DATA_W-1:0] reg_val [6];
        reg_idx = '{rwp_pkg::CFG_SHIFT, rwp_pkg::CFG_CHAN_WIDTH, rwp_pkg::CFG_SEED,
                    rwp_pkg::CFG_START_OFS, rwp_pkg::CFG_INDEX_MODE,
                    rwp_pkg::CFG_WIDE_MODE};
        reg_val = '{32'(shift), 32'(cw), seed, 32'(ofs), 32'(idx_mode), 32'(wide)};
        for (int k = 0; k < 6; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= reg_idx[k];
            cfg_data <= reg_val[k];
            @(negedge clk);
        end
        cfg_we   <= 1'b0;
        wide_now  = wide;
    endtask

    // drain: loads leave no result, so give the pipe time after the last one
    task automatic settle();
        item_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // result side
    initial begin
        int gap;
        forever begin
            if ($urandom_range(0, 39) == 0) result_calm = !result_calm;
            gap = result_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                result_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
            while (!result_if.valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int          phase_items;
        int          len;
        logic [4:0]  shift;
        logic [15:0] cw;
        logic [31:0] seed;
        logic [23:0] ofs;
        logic        idx_mode;
        logic        wide;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_data            = '0;
        item_if.valid       = 1'b0;
        item_if.kind        = ITEM_LOAD;
        item_if.table_index = '0;
        item_if.multiplier  = '0;
        item_if.weight      = '0;
        item_if.first       = 1'b0;
        item_if.last        = 1'b0;
        wide_now            = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // every channel gets an entry before any weight can read it
        for (int i = 0; i < MAX_CHANNELS; i++) send_load(8'(i), rand_mult());

        // reset settings, generator still at zero: no first flag
        send_load(8'd0, 32'h7FFF_FFFF);
        send_load(8'd255, 32'h8000_0001);
        send_weight(32'h0000_007F, 1'b0, 1'b0);
        send_weight(32'hFFFF_FF80, 1'b0, 1'b0);
        send_weight(32'h1234_5600, 1'b0, 1'b1);
        settle();

        // wide mode wrap at both ends
        program_regs(5'd0, 16'd1, 32'hFFFF_FFFF, 24'd0, 1'b0, 1'b1);
        send_weight(32'h7FFF_FFFF, 1'b1, 1'b0);
        send_weight(32'h8000_0000, 1'b0, 1'b0);
        send_weight(32'h0000_0000, 1'b0, 1'b1);
        settle();

        // zero width, quotient at top of range then wrapping to zero
        program_regs(5'd31, 16'd0, 32'd0, 24'hFF_FFFF, 1'b1, 1'b0);
        send_weight(32'd5, 1'b1, 1'b0);
        send_weight(-32'sd5, 1'b0, 1'b0);
        send_weight(32'd100, 1'b0, 1'b1);
        settle();

        // remainder beyond the table, table update inside a tensor
        program_regs(5'd1, 16'hFFFF, 32'h0123_4567, 24'd300, 1'b0, 1'b0);
        send_weight(32'h1234_5680, 1'b1, 1'b0);
        send_weight(32'h0000_0010, 1'b0, 1'b0);
        send_load(8'd7, 32'h0000_0100);
        send_weight(32'hFFFF_FFF0, 1'b0, 1'b1);
        settle();

        // mod mode wrapping channel, tensor continued without first
        program_regs(5'd5, 16'd3, 32'hA5A5_5A5A, 24'd254, 1'b0, 1'b1);
        send_weight($urandom, 1'b1, 1'b0);
        send_weight($urandom, 1'b0, 1'b0);
        send_weight($urandom, 1'b0, 1'b1);
        send_weight($urandom, 1'b0, 1'b0);
        send_weight($urandom, 1'b1, 1'b1);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 4))
                0:       shift = 5'd0;
                1:       shift = 5'd31;
                2:       shift = 5'd1;
                default: shift = 5'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       cw = 16'd0;
                1:       cw = 16'($urandom_range(1, 8));
                2:       cw = 16'($urandom_range(250, 300));
                3:       cw = 16'hFFFF;
                4:       cw = 16'd1;
                default: cw = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       seed = 32'd0;
                1:       seed = 32'hFFFF_FFFF;
                default: seed = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       ofs = 24'hFF_FFFF;
                1:       ofs = 24'($urandom);
                default: ofs = 24'($urandom_range(0, 600));
            endcase
            idx_mode = 1'($urandom);
            wide     = 1'($urandom);
            program_regs(shift, cw, seed, ofs, idx_mode, wide);

            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                case ($urandom_range(0, 19))
                    0, 1: begin
                        send_load(8'($urandom), rand_mult());
                        phase_items++;
                    end
                    2, 3: begin
                        // stray weight with arbitrary flags
                        send_weight(rand_weight(wide_now), 1'($urandom), 1'($urandom));
                        phase_items++;
                    end
                    default: begin
                        len = $urandom_range(1, 40);
                        for (int j = 0; j < len; j++) begin
                            if ($urandom_range(0, 19) == 0) begin
                                send_load(8'($urandom), rand_mult());
                            end
                            send_weight(rand_weight(wide_now), j == 0, j == len - 1);
                        end
                        phase_items += len;
                    end
                endcase
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[rademacher_weight_perturb_top.f]
+incdir+rtl
rtl/rwp_pkg.sv
rtl/rwp_in_if.sv
rtl/rwp_out_if.sv
rtl/rwp_divider.sv
rtl/rwp_datapath.sv
rtl/rwp_ctrl.sv
rtl/rademacher_weight_perturb_top.sv
rtl/rwp_checker.sv
tb/rwp_perturb_checker.sv
tb/tb.sv
